// ===== rtl/core/lla2xyz_pkg.sv =====
package lla2xyz_pkg;

  // field widths
  localparam int ANG_W = 32;   // binary angle units, 2^31 = pi
  localparam int ALT_W = 29;   // metres * 256
  localparam int RAD_W = 31;   // metres * 256, unsigned
  localparam int POS_W = 34;   // metres * 256

  // internal widths
  localparam int TRIG_W = 33;  // q1.30 with headroom for cordic growth
  localparam int ZW     = 33;  // residual angle
  localparam int R_W    = 33;  // radius plus altitude
  localparam int RC_W   = 34;  // r * cos(lat), rounded
  localparam int P1_W   = R_W + TRIG_W;
  localparam int P2_W   = RC_W + TRIG_W;
  localparam int RND_SH = 30;

  localparam int TRIG_STAGES_DEF = 30;
  localparam int ATAN_N          = 32;

  localparam logic [RAD_W-1:0] RADIUS_RST = 31'd1630976000;
  localparam logic signed [TRIG_W-1:0] CORDIC_GAIN = 33'sd652032874;
  localparam logic signed [ZW-1:0] QUARTER_TURN = 33'sd1073741824;
  localparam logic signed [ZW-1:0] HALF_TURN = 33'sd2147483648;

  // arctan(2^-i) in binary angle units
  localparam logic signed [ZW-1:0] ATAN_BAU [0:ATAN_N-1] = '{
    33'sd536870912, 33'sd316933406, 33'sd167458907, 33'sd85004756,
    33'sd42667331,  33'sd21354465,  33'sd10679838,  33'sd5340245,
    33'sd2670163,   33'sd1335087,   33'sd667544,    33'sd333772,
    33'sd166886,    33'sd83443,     33'sd41722,     33'sd20861,
    33'sd10430,     33'sd5215,      33'sd2608,      33'sd1304,
    33'sd652,       33'sd326,       33'sd163,       33'sd81,
    33'sd41,        33'sd20,        33'sd10,        33'sd5,
    33'sd3,         33'sd1,         33'sd1,         33'sd0
  };

endpackage

// ===== rtl/core/lla2xyz_cordic.sv =====
module lla2xyz_cordic
  import lla2xyz_pkg::*;
#(
  parameter int STAGES = TRIG_STAGES_DEF
) (
  input  logic                     clk,
  input  logic signed [ANG_W-1:0]  angle,
  output logic signed [TRIG_W-1:0] sin_q,
  output logic signed [TRIG_W-1:0] cos_q
);

  logic signed [TRIG_W-1:0] x   [0:STAGES];
  logic signed [TRIG_W-1:0] y   [0:STAGES];
  logic signed [ZW-1:0]     z   [0:STAGES];
  logic                     neg [0:STAGES];
  logic signed [ZW-1:0]     ang_ext;

  assign ang_ext = ZW'(angle);

  // fold into [-pi/2, pi/2], flip the sign at the end
  always_ff @(posedge clk) begin
    x[0] <= CORDIC_GAIN;
    y[0] <= '0;
    if (ang_ext > QUARTER_TURN) begin
      z[0]   <= ang_ext - HALF_TURN;
      neg[0] <= 1'b1;
    end else if (ang_ext < -QUARTER_TURN) begin
      z[0]   <= ang_ext + HALF_TURN;
      neg[0] <= 1'b1;
    end else begin
      z[0]   <= ang_ext;
      neg[0] <= 1'b0;
    end
  end

  for (genvar i = 0; i < STAGES; i++) begin : g_stage
    always_ff @(posedge clk) begin
      neg[i+1] <= neg[i];
      if (!z[i][ZW-1]) begin
        x[i+1] <= x[i] - (y[i] >>> i);
        y[i+1] <= y[i] + (x[i] >>> i);
        z[i+1] <= z[i] - ATAN_BAU[i];
      end else begin
        x[i+1] <= x[i] + (y[i] >>> i);
        y[i+1] <= y[i] - (x[i] >>> i);
        z[i+1] <= z[i] + ATAN_BAU[i];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (neg[STAGES]) begin
      cos_q <= -x[STAGES];
      sin_q <= -y[STAGES];
    end else begin
      cos_q <= x[STAGES];
      sin_q <= y[STAGES];
    end
  end

endmodule

// ===== rtl/core/lat_lon_alt_to_earth_centered_xyz_top.sv =====
// Spherical latitude / longitude / altitude to earth-centered x, y, z. Angles
// are 32-bit binary angle units (2^31 = pi), lengths are metres * 256. A word
// is taken whenever start is high; busy never rises, so a new word can enter
// on every clock. Each word gives one result on pos_x / pos_y / pos_z, marked
// by done for exactly one cycle, after it has passed one fold stage,
// TRIG_STAGES cordic stages, one sign stage, then two multiply / round
// pairs. Results leave in input order and the receiver cannot hold them
// off. The earth radius register (wr_en / wr_data) should only be written
// when no word is in flight; a word uses the radius present on the cycle
// it is taken.
module lat_lon_alt_to_earth_centered_xyz_top
  import lla2xyz_pkg::*;
#(
  parameter int TRIG_STAGES = TRIG_STAGES_DEF
) (
  input  logic                    clk,
  input  logic                    rst,
  input  logic                    start,
  output logic                    busy,
  input  logic signed [ANG_W-1:0] latitude,
  input  logic signed [ANG_W-1:0] longitude,
  input  logic signed [ALT_W-1:0] altitude,
  input  logic                    wr_en,
  input  logic [RAD_W-1:0]        wr_data,
  output logic                    done,
  output logic signed [POS_W-1:0] pos_x,
  output logic signed [POS_W-1:0] pos_y,
  output logic signed [POS_W-1:0] pos_z
);

  localparam int CD  = TRIG_STAGES + 2;  // cordic latency
  localparam int LAT = CD + 4;            // total latency

  // earth radius register
  logic [RAD_W-1:0] radius;

  always_ff @(posedge clk) begin
    if (rst) begin
      radius <= RADIUS_RST;
    end else if (wr_en) begin
      radius <= wr_data;
    end
  end

  // never stalls
  assign busy = 1'b0;

  // valid bits ride along with the data
  logic [LAT-1:0] vld;

  always_ff @(posedge clk) begin
    if (rst) begin
      vld <= '0;
    end else begin
      vld <= {vld[LAT-2:0], start & ~busy};
    end
  end

  assign done = vld[LAT-1];

  // radius sum, delayed to meet the cordic outputs
  logic signed [R_W-1:0] r_in;
  logic signed [R_W-1:0] r_pipe [0:CD-1];

  assign r_in = $signed({2'b00, radius}) + R_W'(altitude);

  always_ff @(posedge clk) begin
    r_pipe[0] <= r_in;
    for (int k = 1; k < CD; k++) begin
      r_pipe[k] <= r_pipe[k-1];
    end
  end

  // sine / cosine of both angles
  logic signed [TRIG_W-1:0] sin_lat, cos_lat, sin_lon, cos_lon;

  lla2xyz_cordic #(
    .STAGES(TRIG_STAGES)
  ) u_cordic_lat (
    .clk  (clk),
    .angle(latitude),
    .sin_q(sin_lat),
    .cos_q(cos_lat)
  );

  lla2xyz_cordic #(
    .STAGES(TRIG_STAGES)
  ) u_cordic_lon (
    .clk  (clk),
    .angle(longitude),
    .sin_q(sin_lon),
    .cos_q(cos_lon)
  );

  // stage m1: r * cos(lat), r * sin(lat)
  logic signed [P1_W-1:0]   p_rc, p_z;
  logic signed [TRIG_W-1:0] sin_lon_m1, cos_lon_m1;

  always_ff @(posedge clk) begin
    p_rc       <= P1_W'(r_pipe[CD-1]) * P1_W'(cos_lat);
    p_z        <= P1_W'(r_pipe[CD-1]) * P1_W'(sin_lat);
    sin_lon_m1 <= sin_lon;
    cos_lon_m1 <= cos_lon;
  end

  // stage r1: round to nearest, ties up
  logic signed [P1_W-1:0]   p_rc_rnd, p_z_rnd;
  logic signed [RC_W-1:0]   rc;
  logic signed [POS_W-1:0]  z_r1;
  logic signed [TRIG_W-1:0] sin_lon_r1, cos_lon_r1;

  assign p_rc_rnd = p_rc + (P1_W'(1) <<< (RND_SH - 1));
  assign p_z_rnd  = p_z + (P1_W'(1) <<< (RND_SH - 1));

  always_ff @(posedge clk) begin
    rc         <= p_rc_rnd[RND_SH+RC_W-1:RND_SH];
    z_r1       <= p_z_rnd[RND_SH+POS_W-1:RND_SH];
    sin_lon_r1 <= sin_lon_m1;
    cos_lon_r1 <= cos_lon_m1;
  end

  // stage m2: rc * cos(lon), rc * sin(lon)
  logic signed [P2_W-1:0]  p_x, p_y;
  logic signed [POS_W-1:0] z_m2;

  always_ff @(posedge clk) begin
    p_x  <= P2_W'(rc) * P2_W'(cos_lon_r1);
    p_y  <= P2_W'(rc) * P2_W'(sin_lon_r1);
    z_m2 <= z_r1;
  end

  // stage r2: round and keep the low 34 bits
  logic signed [P2_W-1:0] p_x_rnd, p_y_rnd;

  assign p_x_rnd = p_x + (P2_W'(1) <<< (RND_SH - 1));
  assign p_y_rnd = p_y + (P2_W'(1) <<< (RND_SH - 1));

  always_ff @(posedge clk) begin
    pos_x <= p_x_rnd[RND_SH+POS_W-1:RND_SH];
    pos_y <= p_y_rnd[RND_SH+POS_W-1:RND_SH];
    pos_z <= z_m2;
  end

`ifndef SYNTHESIS
  // every result traces back to a word taken earlier on start
  a_done_has_source: assert property (@(posedge clk) disable iff (rst)
    done |-> $past(start, LAT))
    else $error("result without a matching input word");

  // every word taken comes out as a result marked by done
  a_start_gives_done: assert property (@(posedge clk) disable iff (rst)
    (start && !busy) |-> ##LAT done)
    else $error("input word lost in the pipeline");
`endif

endmodule

// ===== verif/tb_top.sv =====
`timescale 1ns / 100ps

module tb_top;
  import lla2xyz_pkg::*;

  localparam int STAGES          = TRIG_STAGES_DEF;
  // fold + cordic stages + sign + two multiply / round pairs
  localparam int LATENCY         = STAGES + 6;
  localparam int WATCHDOG_LIMIT  = 4000;
  localparam int WORDS_PER_PHASE = 260;
  localparam longint HALF_LSB_Q30 = 64'sd536870912;

  // one earth-centered position, as it appears on the result ports
  typedef struct packed {
    logic signed [POS_W-1:0] x;
    logic signed [POS_W-1:0] y;
    logic signed [POS_W-1:0] z;
  } xyz_word_t;

  // position predictor plus the queue of positions still owed by the block
  class xyz_scoreboard;
    xyz_word_t        pending_pos[$];
    logic [RAD_W-1:0] radius;
    int               errors;

    function new();
      radius = RADIUS_RST;
      errors = 0;
    endfunction

    function bit idle();
      return pending_pos.size() == 0;
    endfunction

    // product of a length with a q1.30 value, rounded to nearest
    function longint round_q30(longint p);
      return (p + HALF_LSB_Q30) >>> RND_SH;
    endfunction

    // rotation-mode cordic with the half-turn fold in front
    function void sin_cos(input longint angle, output longint sin_q30,
                          output longint cos_q30);
      longint x, y, z, xs, ys;
      bit     flip;
      x = CORDIC_GAIN;
      y = 0;
      z = angle;
      flip = 1'b0;
      if (z > QUARTER_TURN) begin
        z = z - HALF_TURN;
        flip = 1'b1;
      end else if (z < -QUARTER_TURN) begin
        z = z + HALF_TURN;
        flip = 1'b1;
      end
      for (int i = 0; i < STAGES; i++) begin
        xs = x >>> i;
        ys = y >>> i;
        if (z >= 0) begin
          x = x - ys;
          y = y + xs;
          z = z - ATAN_BAU[i];
        end else begin
          x = x + ys;
          y = y - xs;
          z = z + ATAN_BAU[i];
        end
      end
      cos_q30 = flip ? -x : x;
      sin_q30 = flip ? -y : y;
    endfunction

    function void note_word(logic signed [ANG_W-1:0] lat, logic signed [ANG_W-1:0] lon,
                            logic signed [ALT_W-1:0] alt);
      longint    r, s_lat, c_lat, s_lon, c_lon, rc, px, py, pz;
      xyz_word_t w;
      r = longint'(radius);
      r = r + longint'(alt);
      sin_cos(longint'(lat), s_lat, c_lat);
      sin_cos(longint'(lon), s_lon, c_lon);
      rc = round_q30(r * c_lat);
      px = round_q30(rc * c_lon);
      py = round_q30(rc * s_lon);
      pz = round_q30(r * s_lat);
      w.x = px[POS_W-1:0];
      w.y = py[POS_W-1:0];
      w.z = pz[POS_W-1:0];
      pending_pos.push_back(w);
    endfunction

    function void check_result(logic signed [POS_W-1:0] x, logic signed [POS_W-1:0] y,
                               logic signed [POS_W-1:0] z);
      xyz_word_t w;
      if (pending_pos.size() == 0) begin
        $display("%0t: unexpected result x=%0d y=%0d z=%0d", $time, x, y, z);
        errors++;
        return;
      end
      w = pending_pos.pop_front();
      if (x !== w.x) begin
        $display("%0t: pos_x expected %0d actual %0d", $time, w.x, x);
        errors++;
      end
      if (y !== w.y) begin
        $display("%0t: pos_y expected %0d actual %0d", $time, w.y, y);
        errors++;
      end
      if (z !== w.z) begin
        $display("%0t: pos_z expected %0d actual %0d", $time, w.z, z);
        errors++;
      end
    endfunction
  endclass

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic start = 1'b0;
  logic busy;
  logic signed [ANG_W-1:0] latitude = '0;
  logic signed [ANG_W-1:0] longitude = '0;
  logic signed [ALT_W-1:0] altitude = '0;
  logic wr_en = 1'b0;
  logic [RAD_W-1:0] wr_data = '0;
  logic done;
  logic signed [POS_W-1:0] pos_x;
  logic signed [POS_W-1:0] pos_y;
  logic signed [POS_W-1:0] pos_z;

  xyz_scoreboard sb;
  int            quiet_cycles = 0;

  lat_lon_alt_to_earth_centered_xyz_top #(
    .TRIG_STAGES(STAGES)
  ) u_dut (
    .clk       (clk),
    .rst       (rst),
    .start     (start),
    .busy      (busy),
    .latitude  (latitude),
    .longitude (longitude),
    .altitude  (altitude),
    .wr_en     (wr_en),
    .wr_data   (wr_data),
    .done      (done),
    .pos_x     (pos_x),
    .pos_y     (pos_y),
    .pos_z     (pos_z)
  );

  // 8 ns clock
  always begin
    #4 clk = 1'b1;
    #4 clk = 1'b0;
  end

  // results are only valid for the one cycle done is high, so take them at
  // the edge that closes that cycle
  always @(posedge clk) begin
    if (!rst && done === 1'b1) begin
      sb.check_result(pos_x, pos_y, pos_z);
    end
  end

  // give up if neither side moves a word for too long
  always @(posedge clk) begin
    if (rst || (start && !busy) || done === 1'b1) begin
      quiet_cycles <= 0;
    end else if (quiet_cycles >= WATCHDOG_LIMIT) begin
      $display("Test completed with failures");
      $finish;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

  // angles at and around the fold points and the ends of the 32-bit range
  function automatic logic [ANG_W-1:0] corner_angle();
    case ($urandom_range(0, 8))
      0: return 32'h0000_0000;
      1: return 32'h4000_0000;
      2: return 32'hC000_0000;
      3: return 32'h4000_0001;
      4: return 32'hBFFF_FFFF;
      5: return 32'h7FFF_FFFF;
      6: return 32'h8000_0000;
      7: return 32'h0000_0001;
      default: return 32'hFFFF_FFFF;
    endcase
  endfunction

  // one word: random sender gaps, then hold start until the block takes it
  task automatic send_word(logic [ANG_W-1:0] lat, logic [ANG_W-1:0] lon,
                           logic [ALT_W-1:0] alt, int idle_pct);
    while ($urandom_range(0, 99) < idle_pct) begin
      // junk on the fields while start is low
      start     <= 1'b0;
      latitude  <= $urandom;
      longitude <= $urandom;
      altitude  <= ALT_W'($urandom);
      @(posedge clk);
    end
    start     <= 1'b1;
    latitude  <= lat;
    longitude <= lon;
    altitude  <= alt;
    @(posedge clk);
    while (busy) @(posedge clk);
    sb.note_word(lat, lon, alt);
  endtask

  task automatic send_random(int idle_pct);
    logic [ANG_W-1:0] lat, lon;
    logic [ALT_W-1:0] alt;
    // mostly legal latitudes, some outside the quarter turn
    case ($urandom_range(0, 9))
      0:       lat = corner_angle();
      1, 2:    lat = $urandom;
      default: lat = $urandom_range(0, 32'h8000_0000) - 32'h4000_0000;
    endcase
    if ($urandom_range(0, 9) == 0) lon = corner_angle();
    else lon = $urandom;
    case ($urandom_range(0, 19))
      0:       alt = 29'h1000_0000;
      1:       alt = 29'h0FFF_FFFF;
      2:       alt = '0;
      default: alt = ALT_W'($urandom);
    endcase
    send_word(lat, lon, alt, idle_pct);
  endtask

  // stop sending and wait until every owed result has come out
  task automatic drain();
    start <= 1'b0;
    @(posedge clk);
    while (!sb.idle()) @(posedge clk);
  endtask

  // radius changes only with the pipeline empty
  task automatic set_radius(logic [RAD_W-1:0] value);
    drain();
    repeat (2) @(posedge clk);
    wr_en   <= 1'b1;
    wr_data <= value;
    sb.radius = value;
    @(posedge clk);
    wr_en <= 1'b0;
  endtask

  logic [RAD_W-1:0] phase_radius [6];
  int               phase_idle   [6] = '{0, 45, 26, 0, 45, 26};

  initial begin
    sb = new();
    // phase 0 runs on the reset radius; a small radius in the last phase
    // makes negative radius sums common
    phase_radius[0] = RADIUS_RST;
    phase_radius[1] = '0;
    phase_radius[2] = 31'h7FFF_FFFF;
    phase_radius[3] = RAD_W'($urandom_range(0, 32'h7FFF_FFFF));
    phase_radius[4] = RADIUS_RST;
    phase_radius[5] = RAD_W'($urandom_range(0, 32'h1000_0000));

    repeat (5) @(posedge clk);
    rst <= 1'b0;

    // directed words, back to back: poles, equator, fold points, the ends
    // of every field and latitudes outside the quarter turn
    send_word(32'h0000_0000, 32'h0000_0000, 29'h0000_0000, 0);
    send_word(32'h4000_0000, 32'h0000_0000, 29'h0000_0000, 0);
    send_word(32'hC000_0000, 32'h0000_0000, 29'h0000_0000, 0);
    send_word(32'h0000_0000, 32'h4000_0000, 29'h0000_0000, 0);
    send_word(32'h0000_0000, 32'hC000_0000, 29'h0000_0000, 0);
    send_word(32'h0000_0000, 32'h4000_0001, 29'h0000_0000, 0);
    send_word(32'h0000_0000, 32'hBFFF_FFFF, 29'h0000_0000, 0);
    send_word(32'h0000_0000, 32'h8000_0000, 29'h0000_0000, 0);
    send_word(32'h0000_0000, 32'h7FFF_FFFF, 29'h0000_0000, 0);
    send_word(32'h4000_0001, 32'h2000_0000, 29'h0000_0100, 0);
    send_word(32'hBFFF_FFFF, 32'hE000_0000, 29'h1FFF_FF00, 0);
    send_word(32'h7FFF_FFFF, 32'h1234_5678, 29'h0FFF_FFFF, 0);
    send_word(32'h8000_0000, 32'h9ABC_DEF0, 29'h1000_0000, 0);
    send_word(32'h4000_0000, 32'h7FFF_FFFF, 29'h0FFF_FFFF, 0);
    send_word(32'hC000_0000, 32'h8000_0000, 29'h1000_0000, 0);
    send_word(32'h0000_0001, 32'hFFFF_FFFF, 29'h0000_0001, 0);
    send_word(32'hFFFF_FFFF, 32'h0000_0001, 29'h1FFF_FFFF, 0);
    send_word(32'h2AAA_AAAA, 32'h5555_5555, 29'h0AAA_AAAA, 0);
    send_word(32'hD555_5555, 32'hAAAA_AAAA, 29'h1555_5555, 0);
    send_word(32'h1000_0000, 32'h3000_0000, 29'h0000_0000, 0);

    for (int ph = 0; ph < 6; ph++) begin
      if (ph > 0) set_radius(phase_radius[ph]);
      for (int n = 0; n < WORDS_PER_PHASE; n++) begin
        // now and then let the pipeline run dry before the next word
        if ((ph == 1 && n == 100) || $urandom_range(0, 299) == 0) drain();
        send_random(phase_idle[ph]);
      end
    end

    drain();
    repeat (LATENCY + 4) @(posedge clk);
    if (sb.errors == 0 && sb.idle()) begin
      $display("Test completed successfully");
    end else begin
      $display("Test completed with failures");
    end
    $finish;
  end

endmodule
